[hw/rtl/gap_buffer_text_editor_assert.svh]
// Assertion macros shared by the gap buffer RTL.
`ifndef GAP_BUFFER_TEXT_EDITOR_ASSERT_SVH
`define GAP_BUFFER_TEXT_EDITOR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GBTE_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define GBTE_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/gbte_pkg.sv]
package gbte_pkg;

  // Default store size in bytes.
  localparam int GBTE_CAPACITY = 4096;

  // Field widths fixed by the item format.
  localparam int CMD_W  = 3;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 13;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Byte that marks a line end.
  localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'h0A;

  // Command codes carried in the item.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_BKSP   = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_MOVE   = 3'd3,
    CMD_READ   = 3'd4
  } gbte_cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_CAPT,
    S_MV_STEP,
    S_MV_WR,
    S_DONE
  } gbte_state_t;

  // Operand selects of the shared address adder.
  typedef enum logic {
    AU_A_BGC,
    AU_A_POS
  } gbte_au_a_t;

  typedef enum logic [1:0] {
    AU_B_ZERO,
    AU_B_MINUS1,
    AU_B_FREE
  } gbte_au_b_t;

  // Flags and read byte handed from the sequencer to the output register.
  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic              changed;
    logic              newline_removed;
    logic              full_res;
  } gbte_res_t;

endpackage

[hw/rtl/gbte_ram.sv]
module gbte_ram
  import gbte_pkg::*;
#(
  parameter int WIDTH = CHAR_W,
  parameter int DEPTH = GBTE_CAPACITY,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/gbte_seq.sv]
module gbte_seq
  import gbte_pkg::*;
#(
  parameter int CAPACITY = GBTE_CAPACITY,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [CHAR_W-1:0] ch,
  input  logic [POS_W-1:0]  pos,
  input  logic              res_ready,
  output logic              idle,
  output logic              res_valid,
  output gbte_res_t         res,
  output logic [CW-1:0]     bgc,
  output logic [CW-1:0]     len,
  output logic [CW-1:0]     free,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [CHAR_W-1:0] mem_wdata,
  output logic [AW-1:0]     mem_raddr,
  input  logic [CHAR_W-1:0] mem_rdata
);

  localparam int PW = (CW > POS_W) ? CW : POS_W;

  gbte_state_t        state_r, state_nxt;
  logic [CMD_W-1:0]   cmd_r;
  logic [CHAR_W-1:0]  ch_r;
  logic [POS_W-1:0]   pos_r;
  logic [CW-1:0]      bgc_r, bgc_nxt;
  logic [CW-1:0]      len_r, len_nxt;
  logic [CW-1:0]      free_r, free_nxt;
  logic [CW-1:0]      target_r, target_nxt;
  logic               dir_r, dir_nxt;
  gbte_res_t          res_r, res_nxt;

  logic [PW-1:0]      pos_x, bgc_x, len_x;
  logic [CW-1:0]      target_w;
  logic               pos_lt_bgc, pos_lt_len, bgc_lt_tgt, bgc_gt_tgt;
  gbte_au_a_t         au_a_sel;
  gbte_au_b_t         au_b_sel;
  logic [CW-1:0]      au_a, au_b, au_sum;

  // Compares against the cursor, the length and the move target.
  assign pos_x      = PW'(pos_r);
  assign bgc_x      = PW'(bgc_r);
  assign len_x      = PW'(len_r);
  assign pos_lt_bgc = pos_x < bgc_x;
  assign pos_lt_len = pos_x < len_x;
  assign target_w   = (pos_x > len_x) ? len_r : pos_x[CW-1:0];
  assign bgc_lt_tgt = bgc_r < target_r;
  assign bgc_gt_tgt = bgc_r > target_r;

  // Shared address adder: every memory address is the cursor or the read
  // index plus zero, minus one, or the free gap size.
  always_comb begin
    au_a = (au_a_sel == AU_A_POS) ? pos_x[CW-1:0] : bgc_r;
    unique case (au_b_sel)
      AU_B_ZERO:   au_b = '0;
      AU_B_MINUS1: au_b = '1;
      AU_B_FREE:   au_b = free_r;
      default:     au_b = '0;
    endcase
  end
  assign au_sum = au_a + au_b;

  // Item capture on acceptance.
  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r <= cmd;
      ch_r  <= ch;
      pos_r <= pos;
    end
    target_r <= target_nxt;
    res_r    <= res_nxt;
  end

  // Control state and gap counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bgc_r   <= '0;
      len_r   <= '0;
      free_r  <= CW'(CAPACITY);
      dir_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bgc_r   <= bgc_nxt;
      len_r   <= len_nxt;
      free_r  <= free_nxt;
      dir_r   <= dir_nxt;
    end
  end

  // Next state and counter updates.
  always_comb begin
    state_nxt  = state_r;
    bgc_nxt    = bgc_r;
    len_nxt    = len_r;
    free_nxt   = free_r;
    dir_nxt    = dir_r;
    target_nxt = target_r;
    res_nxt    = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          res_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (free_r != '0) begin
              bgc_nxt         = bgc_r + CW'(1);
              len_nxt         = len_r + CW'(1);
              free_nxt        = free_r - CW'(1);
              res_nxt.changed = 1'b1;
            end else begin
              res_nxt.full_res = 1'b1;
            end
          end
          CMD_BKSP: begin
            if (bgc_r != '0) begin
              bgc_nxt         = bgc_r - CW'(1);
              len_nxt         = len_r - CW'(1);
              free_nxt        = free_r + CW'(1);
              res_nxt.changed = 1'b1;
              state_nxt       = S_RD_CAPT;
            end
          end
          CMD_DELETE: begin
            if (len_r != bgc_r) begin
              len_nxt         = len_r - CW'(1);
              free_nxt        = free_r + CW'(1);
              res_nxt.changed = 1'b1;
            end
          end
          CMD_MOVE: begin
            target_nxt      = target_w;
            res_nxt.changed = (target_w != bgc_r);
            state_nxt       = S_MV_STEP;
          end
          CMD_READ: begin
            if (pos_lt_len) begin
              state_nxt = S_RD_CAPT;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RD_CAPT: begin
        // The byte addressed in the previous cycle is now on the read port.
        if (cmd_r == CMD_READ) begin
          res_nxt.read_char = mem_rdata;
        end else begin
          res_nxt.newline_removed = (mem_rdata == NEWLINE_BYTE);
        end
        state_nxt = S_DONE;
      end
      S_MV_STEP: begin
        priority if (bgc_lt_tgt) begin
          dir_nxt   = 1'b1;
          state_nxt = S_MV_WR;
        end else if (bgc_gt_tgt) begin
          dir_nxt   = 1'b0;
          bgc_nxt   = bgc_r - CW'(1);
          state_nxt = S_MV_WR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MV_WR: begin
        if (dir_r) begin
          bgc_nxt = bgc_r + CW'(1);
        end
        state_nxt = S_MV_STEP;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Memory controls, adder operand selects and handshake outputs.
  always_comb begin
    au_a_sel  = AU_A_BGC;
    au_b_sel  = AU_B_ZERO;
    mem_we    = 1'b0;
    mem_wdata = ch_r;
    idle      = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        idle = 1'b1;
      end
      S_EXEC: begin
        unique case (cmd_r)
          CMD_INSERT: begin
            mem_we = (free_r != '0);
          end
          CMD_BKSP: begin
            au_b_sel = AU_B_MINUS1;
          end
          CMD_READ: begin
            // Below the cursor the index is the address; above it the gap
            // is skipped.
            au_a_sel = AU_A_POS;
            au_b_sel = pos_lt_bgc ? AU_B_ZERO : AU_B_FREE;
          end
          default: begin
            au_b_sel = AU_B_ZERO;
          end
        endcase
      end
      S_RD_CAPT: begin
        au_b_sel = AU_B_ZERO;
      end
      S_MV_STEP: begin
        // Right: read the first byte above the gap. Left: the last below it.
        au_b_sel = bgc_lt_tgt ? AU_B_FREE : AU_B_MINUS1;
      end
      S_MV_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        au_b_sel  = dir_r ? AU_B_ZERO : AU_B_FREE;
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        idle = 1'b0;
      end
    endcase
  end

  assign mem_waddr = au_sum[AW-1:0];
  assign mem_raddr = au_sum[AW-1:0];
  assign res       = res_r;
  assign bgc       = bgc_r;
  assign len       = len_r;
  assign free      = free_r;

endmodule

[hw/rtl/gap_buffer_text_editor.sv]
// Gap-buffer text store with a cursor. Each input item is one command (insert,
// backspace, delete, move cursor, read) and yields exactly one result item
// carrying the read byte, the changed, newline-removed and full flags, and the
// cursor and text length after the command. The block handles one item at a
// time. After acceptance, insert, delete, unused codes, a backspace at the
// start of the text and a read past the end go from S_EXEC to S_DONE; a
// backspace that removes a byte and a read inside the text pass S_RD_CAPT
// between them; a move passes S_MV_STEP and S_MV_WR once for each byte walked
// across the gap, then S_MV_STEP once more, before S_DONE. The block is ready
// for the next item when the result enters the output register. The order is
// set by the single text memory, whose read is registered, and by the one
// shared address adder, which serve one access per cycle; a moved byte is read
// in S_MV_STEP and written in S_MV_WR. A finished result waits in the output
// register, so the next item is accepted while it is unclaimed. The store
// needs no clearing after reset; bytes are only read after they were written.
`include "gap_buffer_text_editor_assert.svh"

module gap_buffer_text_editor
  import gbte_pkg::*;
#(
  parameter int CAPACITY = GBTE_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // char_in [7:0], position [20:8], zero [23:21]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd [2:0]
  input  logic [CMD_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // read_char [7:0], changed [8], newline_removed [9], full_res [10],
  // cursor_pos [23:11], text_len [36:24], zero [39:37]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic              in_acc;
  logic              seq_idle, seq_res_valid, res_ready;
  gbte_res_t         seq_res;
  logic [CW-1:0]     bgc_w, len_w, free_w;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata, mem_rdata;
  logic [PW-1:0]     bgc_x, len_x;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = seq_idle;
  assign res_ready = !out_tvalid_r || out_tready;

  // Command sequencer with the gap counts and the shared address adder.
  gbte_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc),
    .cmd       (in_tuser),
    .ch        (in_tdata[CHAR_W-1:0]),
    .pos       (in_tdata[CHAR_W+POS_W-1:CHAR_W]),
    .res_ready (res_ready),
    .idle      (seq_idle),
    .res_valid (seq_res_valid),
    .res       (seq_res),
    .bgc       (bgc_w),
    .len       (len_w),
    .free      (free_w),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Text store.
  gbte_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Cursor and length reported on 13 bits.
  assign bgc_x = PW'(bgc_w);
  assign len_x = PW'(len_w);

  // Output register: loads a finished result when empty or being drained.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (seq_res_valid && res_ready) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {3'b000, len_x[POS_W-1:0], bgc_x[POS_W-1:0],
                        seq_res.full_res, seq_res.newline_removed,
                        seq_res.changed, seq_res.read_char};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The cursor never passes the end of the text.
  `GBTE_ASSERT_IMP(a_cursor_in_text, clk, rst_n, 1'b1, bgc_w <= len_w, "cursor beyond text")
  // Text length and free gap always add up to the capacity.
  `GBTE_ASSERT_IMP(a_len_free_sum, clk, rst_n, 1'b1, (len_w + free_w) == CAPACITY, "gap size lost")
  // An accepted item keeps the block busy in the next cycle.
  `GBTE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, !in_tready, "ready after accept")
  // A finished result stays offered until the output register takes it.
  `GBTE_ASSERT_NXT(a_res_held, clk, rst_n, seq_res_valid && !res_ready, seq_res_valid, "result dropped")

endmodule
